FILE: rtl/cck_pkg.sv
// Shared types, constants and calendar helper functions for the second-tick calendar clock.
package cck_pkg;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;

    localparam int unsigned YEAR_MAX = 9999;

    localparam logic [SECOND_W-1:0] SECOND_LAST = SECOND_W'(59);
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = MINUTE_W'(59);
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
    localparam logic [MONTH_W-1:0]  MONTH_LAST  = MONTH_W'(12);
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = MONTH_W'(2);
    localparam logic [DAY_W-1:0]    FEB_LEAP    = DAY_W'(29);
    localparam logic [YEAR_W-1:0]   YEAR_LAST   = YEAR_W'(YEAR_MAX);

    // Multiplicative inverse of 25 modulo 2**14 and the largest 14-bit
    // multiple quotient. A year is a multiple of 25 exactly when its product
    // with the inverse, kept to 14 bits, does not exceed the limit.
    localparam logic [YEAR_W-1:0] INV25       = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(655);

    localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
        DAY_W'(31), DAY_W'(31), DAY_W'(28), DAY_W'(31),
        DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31),
        DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(31), DAY_W'(31)
    };

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                command;
        logic [HOUR_W-1:0]   load_hours;
        logic [MINUTE_W-1:0] load_minutes;
        logic [SECOND_W-1:0] load_seconds;
        logic [DAY_W-1:0]    load_day;
        logic [MONTH_W-1:0]  load_month;
        logic [YEAR_W-1:0]   load_year;
    } req_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } cal_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic                day_rolled;
        logic                load_rejected;
    } rsp_t;

    // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
    // With the factor 4 known, 100 and 400 reduce to the factor 25.
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] len;
        len = MONTH_DAYS[m];
        if ((m == MONTH_FEB) && leap_year(y))
        begin
            len = FEB_LEAP;
        end
        return len;
    endfunction

endpackage

FILE: rtl/cck_if.sv
// Valid/ready channel interfaces for requests and results of the calendar clock.
interface cck_req_if;
    logic          valid;
    logic          ready;
    cck_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cck_rsp_if;
    logic          valid;
    logic          ready;
    cck_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/calendar_clock_second_tick.sv
// Calendar clock: each tick request adds one second to a Gregorian date and time of day
// (starting at 00:00:00 on 1 January of year 1 after reset), and each load request replaces
// the date and time if every value is valid, otherwise it is refused with load_rejected set.
// One request is taken per clock cycle while results drain; each gives exactly one result,
// which passes through the input register and then the result register. A single update
// stage lies between them, and its longest path is the 14-bit leap-year multiply and
// compare feeding the month-length check. Results are held in the output register while
// rsp.ready is low, and the input register keeps taking requests as long as that register
// drains.
module calendar_clock_second_tick (
    input  logic      clk,
    input  logic      rst_n,
    cck_req_if.sink   req,
    cck_rsp_if.source rsp
);

    logic          held_valid;
    cck_pkg::req_t held_req;
    logic          advance;
    cck_pkg::cal_t state_reg;
    cck_pkg::cal_t state_next;
    logic          rolled;
    logic          rejected;
    logic          rsp_valid_reg;
    cck_pkg::rsp_t rsp_reg;

    assign advance = held_valid && (!rsp_valid_reg || rsp.ready);

    cck_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    cck_next u_next (
        .cur      (state_reg),
        .req      (held_req),
        .nxt      (state_next),
        .rolled   (rolled),
        .rejected (rejected)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hours   <= '0;
            state_reg.minutes <= '0;
            state_reg.seconds <= '0;
            state_reg.day     <= cck_pkg::DAY_W'(1);
            state_reg.month   <= cck_pkg::MONTH_W'(1);
            state_reg.year    <= cck_pkg::YEAR_W'(1);
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.hours         <= state_next.hours;
            rsp_reg.minutes       <= state_next.minutes;
            rsp_reg.seconds       <= state_next.seconds;
            rsp_reg.day           <= state_next.day;
            rsp_reg.month         <= state_next.month;
            rsp_reg.year          <= state_next.year;
            rsp_reg.day_rolled    <= rolled;
            rsp_reg.load_rejected <= rejected;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // A refused load must leave the date and time untouched.
    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rejected |=> $stable(state_reg))
        else $error("refused load changed the clock state");

    // A pending result always shows the current state.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.hours == state_reg.hours)
                       && (rsp_reg.minutes == state_reg.minutes)
                       && (rsp_reg.seconds == state_reg.seconds)
                       && (rsp_reg.day == state_reg.day)
                       && (rsp_reg.month == state_reg.month)
                       && (rsp_reg.year == state_reg.year))
        else $error("result does not match clock state");

    a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seconds <= cck_pkg::SECOND_LAST)
        && (state_reg.minutes <= cck_pkg::MINUTE_LAST)
        && (state_reg.hours <= cck_pkg::HOUR_LAST)
        && (state_reg.month != '0) && (state_reg.month <= cck_pkg::MONTH_LAST)
        && (state_reg.day != '0)
        && (state_reg.year != '0) && (state_reg.year <= cck_pkg::YEAR_LAST))
        else $error("clock state out of range");

    a_rollover_at_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.day_rolled |-> (rsp_reg.hours == '0)
                                             && (rsp_reg.minutes == '0)
                                             && (rsp_reg.seconds == '0)
                                             && !rsp_reg.load_rejected)
        else $error("day rollover flagged away from midnight");

endmodule

FILE: rtl/cck_in_stage.sv
// Input register that holds one request until the update stage takes it.
module cck_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    cck_req_if.sink       req,
    input  logic          advance,
    output logic          held_valid,
    output cck_pkg::req_t held_req
);

    logic          valid_reg;
    logic          valid_next;
    cck_pkg::req_t data_reg;

    // The register may refill in the same cycle that its content moves on.
    assign req.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.ready)
        begin
            valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            data_reg <= req.data;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = data_reg;

endmodule

FILE: rtl/cck_next.sv
// Next-state logic: one-second carry chain with calendar rollover, or a checked load.
module cck_next (
    input  cck_pkg::cal_t cur,
    input  cck_pkg::req_t req,
    output cck_pkg::cal_t nxt,
    output logic          rolled,
    output logic          rejected
);

    logic                         sec_wrap;
    logic                         min_wrap;
    logic                         hour_wrap;
    logic [cck_pkg::DAY_W-1:0]    cur_len;
    logic [cck_pkg::DAY_W-1:0]    load_len;
    logic                         load_ok;
    cck_pkg::cal_t                tick_cal;

    assign sec_wrap  = (cur.seconds >= cck_pkg::SECOND_LAST);
    assign min_wrap  = sec_wrap && (cur.minutes >= cck_pkg::MINUTE_LAST);
    assign hour_wrap = min_wrap && (cur.hours >= cck_pkg::HOUR_LAST);

    assign cur_len  = cck_pkg::month_length(cur.month, cur.year);
    assign load_len = cck_pkg::month_length(req.load_month, req.load_year);

    assign load_ok = (req.load_hours <= cck_pkg::HOUR_LAST)
                  && (req.load_minutes <= cck_pkg::MINUTE_LAST)
                  && (req.load_seconds <= cck_pkg::SECOND_LAST)
                  && (req.load_month != '0)
                  && (req.load_month <= cck_pkg::MONTH_LAST)
                  && (req.load_year != '0)
                  && (req.load_year <= cck_pkg::YEAR_LAST)
                  && (req.load_day != '0)
                  && (req.load_day <= load_len);

    always_comb
    begin
        tick_cal = cur;
        tick_cal.seconds = sec_wrap ? '0 : cur.seconds + cck_pkg::SECOND_W'(1);
        if (sec_wrap)
        begin
            tick_cal.minutes = min_wrap ? '0 : cur.minutes + cck_pkg::MINUTE_W'(1);
        end
        if (min_wrap)
        begin
            tick_cal.hours = hour_wrap ? '0 : cur.hours + cck_pkg::HOUR_W'(1);
        end
        if (hour_wrap)
        begin
            if (cur.day < cur_len)
            begin
                tick_cal.day = cur.day + cck_pkg::DAY_W'(1);
            end
            else if (cur.month >= cck_pkg::MONTH_LAST)
            begin
                tick_cal.day   = cck_pkg::DAY_W'(1);
                tick_cal.month = cck_pkg::MONTH_W'(1);
                tick_cal.year  = (cur.year >= cck_pkg::YEAR_LAST) ? cck_pkg::YEAR_W'(1)
                                                                  : cur.year + cck_pkg::YEAR_W'(1);
            end
            else
            begin
                tick_cal.day   = cck_pkg::DAY_W'(1);
                tick_cal.month = cur.month + cck_pkg::MONTH_W'(1);
            end
        end
    end

    always_comb
    begin
        nxt      = cur;
        rolled   = 1'b0;
        rejected = 1'b0;
        case (req.command)
            cck_pkg::CMD_TICK:
            begin
                nxt    = tick_cal;
                rolled = hour_wrap;
            end
            cck_pkg::CMD_LOAD:
            begin
                if (load_ok)
                begin
                    nxt.hours   = req.load_hours;
                    nxt.minutes = req.load_minutes;
                    nxt.seconds = req.load_seconds;
                    nxt.day     = req.load_day;
                    nxt.month   = req.load_month;
                    nxt.year    = req.load_year;
                end
                else
                begin
                    rejected = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
